>>> hw/rtl/utf8nv_pkg.sv
package utf8nv_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 16;
   localparam int unsigned CodeWidth  = 21;

   localparam logic [CountWidth-1:0] MaxNameBytesReset = 16'd64;

   typedef enum logic [3:0] {
      ERR_NONE       = 4'd0,
      ERR_EMPTY      = 4'd1,
      ERR_TOO_LONG   = 4'd2,
      ERR_BAD_LEAD   = 4'd3,
      ERR_TRUNCATED  = 4'd4,
      ERR_BAD_CONT   = 4'd5,
      ERR_OVERLONG   = 4'd6,
      ERR_SURROGATE  = 4'd7,
      ERR_ABOVE      = 4'd8,
      ERR_CONTROL    = 4'd9
   } error_kind_type;

   typedef struct packed {
      logic [CountWidth-1:0] byte_count;
      logic [1:0]            bytes_pending;
      logic [1:0]            sequence_length;
      logic [CodeWidth-1:0]  code_accumulator;
      error_kind_type        first_error;
   } stream_state_type;

   typedef struct packed {
      logic [ByteWidth-1:0] byte_value;
      logic                 has_byte;
      logic                 last_byte;
   } word_type;

endpackage

>>> hw/rtl/utf8nv_step.sv
module utf8nv_step (
   input  utf8nv_pkg::stream_state_type state,
   input  utf8nv_pkg::word_type         word,
   input  logic [15:0]                  max_name_bytes,
   output utf8nv_pkg::stream_state_type state_in,
   output logic                         name_ok,
   output utf8nv_pkg::error_kind_type   error_kind
);
   import utf8nv_pkg::*;

   function automatic logic is_control(input logic [CodeWidth-1:0] cp);
      is_control = (cp < 21'h20) || (cp >= 21'h7f && cp <= 21'h9f);
   endfunction

   always_comb begin
      stream_state_type      st;
      error_kind_type        byte_err;
      error_kind_type        dec_err;
      error_kind_type        end_err;
      logic [CountWidth:0]   next_count;
      logic [ByteWidth-1:0]  b;
      logic [CodeWidth-1:0]  cp;
      logic                  overlong;

      st         = state;
      byte_err   = ERR_NONE;
      dec_err    = ERR_NONE;
      end_err    = ERR_NONE;
      b          = word.byte_value;
      next_count = {1'b0, state.byte_count} + {{CountWidth{1'b0}}, 1'b1};
      cp         = '0;
      overlong   = 1'b0;

      if (word.has_byte) begin
         if (next_count > {1'b0, max_name_bytes}) begin
            byte_err = ERR_TOO_LONG;
         end
         st.byte_count = next_count[CountWidth] ? {CountWidth{1'b1}}
                                                : next_count[CountWidth-1:0];
         if (state.bytes_pending == 2'd0) begin
            if (b <= 8'h7f) begin
               if (is_control({13'd0, b})) begin
                  dec_err = ERR_CONTROL;
               end
            end else if (b >= 8'hc2 && b <= 8'hdf) begin
               st.code_accumulator = {16'd0, b[4:0]};
               st.bytes_pending    = 2'd1;
               st.sequence_length  = 2'd1;
            end else if (b >= 8'he0 && b <= 8'hef) begin
               st.code_accumulator = {17'd0, b[3:0]};
               st.bytes_pending    = 2'd2;
               st.sequence_length  = 2'd2;
            end else if (b >= 8'hf0 && b <= 8'hf4) begin
               st.code_accumulator = {18'd0, b[2:0]};
               st.bytes_pending    = 2'd3;
               st.sequence_length  = 2'd3;
            end else begin
               dec_err = ERR_BAD_LEAD;
            end
         end else if (b[7:6] != 2'b10) begin
            dec_err          = ERR_BAD_CONT;
            st.bytes_pending = 2'd0;
         end else begin
            cp                  = {state.code_accumulator[CodeWidth-7:0], b[5:0]};
            st.code_accumulator = cp;
            st.bytes_pending    = state.bytes_pending - 2'd1;
            if (state.bytes_pending == 2'd1) begin
               overlong = (state.sequence_length == 2'd1 && cp < 21'h80) ||
                          (state.sequence_length == 2'd2 && cp < 21'h800) ||
                          (state.sequence_length == 2'd3 && cp < 21'h10000);
               if (overlong) begin
                  dec_err = ERR_OVERLONG;
               end else if (cp >= 21'hd800 && cp <= 21'hdfff) begin
                  dec_err = ERR_SURROGATE;
               end else if (cp > 21'h10ffff) begin
                  dec_err = ERR_ABOVE;
               end else if (is_control(cp)) begin
                  dec_err = ERR_CONTROL;
               end
            end
         end
         if (byte_err == ERR_NONE) begin
            byte_err = dec_err;
         end
         if (st.first_error == ERR_NONE) begin
            st.first_error = byte_err;
         end
      end

      if (st.byte_count == '0) begin
         end_err = ERR_EMPTY;
      end else if (st.bytes_pending != 2'd0) begin
         end_err = ERR_TRUNCATED;
      end

      error_kind = (st.first_error == ERR_NONE) ? end_err : st.first_error;
      name_ok    = (error_kind == ERR_NONE);

      if (word.last_byte) begin
         st = '{byte_count: '0, bytes_pending: 2'd0, sequence_length: 2'd0,
                code_accumulator: '0, first_error: ERR_NONE};
      end
      state_in = st;
   end

endmodule

>>> hw/rtl/utf8_name_validator.sv
// Strict UTF-8 check of a name, one byte per word on the req channel. A word
// with last_byte set closes the name and yields one rsp word (name_ok and the
// first error in stream order); other words yield none, and a word with
// neither has_byte nor last_byte is ignored. Throughput is one word per clock
// while the rsp side keeps up: each word sits in the input register while the
// decode step updates the stream state, and its verdict sits in the output
// register, which drives rsp_valid once the closing word has left the input
// register; a closing word waits there while the previous verdict is unread.
// csr_write_data sets the longest accepted name in bytes (reset 64); the user
// must write it only while idle, and the block does not enforce this.
module utf8_name_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_has_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_name_ok,
   output logic [3:0]  rsp_error_kind,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import utf8nv_pkg::*;

   logic                  in_valid_ff;
   word_type              word_ff;
   stream_state_type      state_ff;
   stream_state_type      state_in;
   logic [CountWidth-1:0] max_name_bytes_ff;
   logic                  rsp_valid_ff;
   logic                  name_ok_ff;
   error_kind_type        error_kind_ff;
   logic                  name_ok_in;
   error_kind_type        error_kind_in;
   logic                  advance;

   // hold a closing word while the previous verdict is still waiting
   assign advance   = in_valid_ff && (!word_ff.last_byte || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   utf8nv_step u_step (
      .state          (state_ff),
      .word           (word_ff),
      .max_name_bytes (max_name_bytes_ff),
      .state_in       (state_in),
      .name_ok        (name_ok_in),
      .error_kind     (error_kind_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         max_name_bytes_ff <= MaxNameBytesReset;
         state_ff          <= '{byte_count: '0, bytes_pending: 2'd0,
                                sequence_length: 2'd0, code_accumulator: '0,
                                first_error: ERR_NONE};
      end else begin
         if (csr_write_enable) begin
            max_name_bytes_ff <= csr_write_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && word_ff.last_byte) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= '{byte_value: req_byte_value, has_byte: req_has_byte,
                      last_byte: req_last_byte};
      end
      if (advance && word_ff.last_byte) begin
         name_ok_ff    <= name_ok_in;
         error_kind_ff <= error_kind_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_name_ok    = name_ok_ff;
   assign rsp_error_kind = error_kind_ff;

endmodule
